### design/slwc_pkg.sv
// Shared types and constants for the set-associative write-back cache tag store.
package slwc_pkg;

	localparam int ADDR_BITS = 32;
	localparam int CFG_DATA_BITS = 5;

	// Register reset values
	localparam logic [4:0] LOG_CACHE_RST = 5'd15;
	localparam logic [3:0] LOG_BLOCK_RST = 4'd5;
	localparam logic [1:0] LOG_WAYS_RST = 2'd2;

	typedef enum logic [1:0] {
		CFG_LOG_CACHE = 2'd0,
		CFG_LOG_BLOCK = 2'd1,
		CFG_LOG_WAYS  = 2'd2
	} cfg_reg_t;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic hit;
		logic writeback_valid;
		logic [ADDR_BITS-1:0] writeback_address;
		logic fill_valid;
		logic [ADDR_BITS-1:0] fill_address;
		logic [31:0] read_accesses;
		logic [31:0] write_accesses;
		logic [31:0] read_misses;
		logic [31:0] write_misses;
		logic [31:0] writeback_total;
	} rsp_t;

	typedef struct packed {
		logic [1:0] reg_index;
		logic [CFG_DATA_BITS-1:0] value;
	} cfg_t;

endpackage

### design/slwc_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface slwc_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/slwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### design/set_assoc_lru_writeback_cache.sv
// A request beat is registered into stage s1 on acceptance, its result beat when s1
// advances. One access per cycle unless rsp stalls or the sweep runs; the set RAM
// is read at acceptance and written when s1 advances, with a bypass register for
// back-to-back accesses to the same set. Reset restores configuration defaults and
// clears counters and handshake state, then sweeps the set RAM one row a cycle with
// req.ready low. Configuration writes are taken every cycle, including the sweep.
module set_assoc_lru_writeback_cache #(
	parameter int ADDR_WIDTH = 32,
	parameter int MAX_INDEX_BITS = 10,
	parameter int MAX_WAYS = 8,
	parameter int AGE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	slwc_chan_if.sink   req,
	slwc_chan_if.source rsp,
	slwc_chan_if.sink   cfg
);
	import slwc_pkg::*;

	localparam int TAG_W = (ADDR_WIDTH < ADDR_BITS) ? ADDR_WIDTH : ADDR_BITS;
	localparam int SET_DEPTH = 1 << MAX_INDEX_BITS;
	localparam int SET_AW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
	localparam int WAY_W = 2 + TAG_W + AGE_WIDTH;
	localparam int ROW_W = MAX_WAYS * WAY_W;
	localparam int WAY_AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	// Configuration
	logic [4:0] log_cache_q;
	logic [3:0] log_block_q;
	logic [1:0] log_ways_q;

	// Geometry
	logic signed [6:0] ib_raw;
	logic [4:0] ib_c;
	logic [5:0] tsh;
	logic [3:0] ways_n;
	logic [TAG_W-1:0] ones;

	// Handshake and pipeline
	logic clr_busy_q;
	logic [SET_AW-1:0] clr_addr_q;
	logic s1_valid_q;
	logic s1_adv;
	logic req_fire;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic op_s1;
	logic [TAG_W-1:0] addr_s1;
	logic fwd_s1;
	logic [ROW_W-1:0] fwd_row_s1;
	logic [SET_AW-1:0] idx_in;
	logic [SET_AW-1:0] idx_s1;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] new_row;
	logic ram_we;
	logic [SET_AW-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;

	// Counters
	logic [31:0] rd_acc_q, wr_acc_q, rd_miss_q, wr_miss_q, wb_tot_q;
	logic [31:0] rd_acc_n, wr_acc_n, rd_miss_n, wr_miss_n, wb_tot_n;

	// Lookup results
	logic hit;
	logic wb;
	logic [TAG_W-1:0] wb_addr;
	logic [TAG_W-1:0] tag_s1;

	function automatic logic [SET_AW-1:0] idx_of(input logic [TAG_W-1:0] a,
			input logic [3:0] b, input logic [4:0] ib);
		logic [TAG_W-1:0] tmp;
		tmp = (a >> b) & ~({TAG_W{1'b1}} << ib);
		return tmp[SET_AW-1:0];
	endfunction

	assign ones = {TAG_W{1'b1}};

	always_comb begin
		ib_raw = $signed({2'b00, log_cache_q}) - $signed({3'b000, log_block_q})
			- $signed({5'b00000, log_ways_q});
		if (ib_raw < 0) begin
			ib_c = 5'd0;
		end else if (ib_raw > $signed(7'(MAX_INDEX_BITS))) begin
			ib_c = 5'(MAX_INDEX_BITS);
		end else begin
			ib_c = ib_raw[4:0];
		end
		tsh = {2'b00, log_block_q} + {1'b0, ib_c};
		ways_n = 4'd1 << log_ways_q;
	end

	// Configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_cache_q <= LOG_CACHE_RST;
			log_block_q <= LOG_BLOCK_RST;
			log_ways_q <= LOG_WAYS_RST;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				CFG_LOG_CACHE: log_cache_q <= cfg.data.value[4:0];
				CFG_LOG_BLOCK: log_block_q <= cfg.data.value[3:0];
				CFG_LOG_WAYS:  log_ways_q <= cfg.data.value[1:0];
				default: ;
			endcase
		end
	end

	// Handshake
	assign s1_adv = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign req_fire = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	assign idx_in = idx_of(req.data.address[TAG_W-1:0], log_block_q, ib_c);
	assign idx_s1 = idx_of(addr_s1, log_block_q, ib_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			s1_valid_q <= 1'b0;
			fwd_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			rd_acc_q <= '0;
			wr_acc_q <= '0;
			rd_miss_q <= '0;
			wr_miss_q <= '0;
			wb_tot_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == SET_AW'(SET_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (req_fire) begin
				s1_valid_q <= 1'b1;
				// Same set still being written: take the row from the bypass
				fwd_s1 <= s1_adv && (idx_in == idx_s1);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
				rd_acc_q <= rd_acc_n;
				wr_acc_q <= wr_acc_n;
				rd_miss_q <= rd_miss_n;
				wr_miss_q <= wr_miss_n;
				wb_tot_q <= wb_tot_n;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1 <= req.data.opcode;
			addr_s1 <= req.data.address[TAG_W-1:0];
			fwd_row_s1 <= new_row;
		end
		if (s1_adv) begin
			rsp_q.hit <= hit;
			rsp_q.writeback_valid <= wb;
			rsp_q.writeback_address <= ADDR_BITS'(wb_addr);
			rsp_q.fill_valid <= !hit;
			rsp_q.fill_address <= hit ? '0 : ADDR_BITS'(addr_s1);
			rsp_q.read_accesses <= rd_acc_n;
			rsp_q.write_accesses <= wr_acc_n;
			rsp_q.read_misses <= rd_miss_n;
			rsp_q.write_misses <= wr_miss_n;
			rsp_q.writeback_total <= wb_tot_n;
		end
	end

	// Set RAM: one row holds every way of a set
	assign ram_we = clr_busy_q || s1_adv;
	assign ram_waddr = clr_busy_q ? clr_addr_q : idx_s1;
	assign ram_wdata = clr_busy_q ? '0 : new_row;

	slwc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SET_DEPTH)
	) u_set_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(req_fire),
		.raddr(idx_in),
		.rdata(ram_rdata)
	);

	assign row_s1 = fwd_s1 ? fwd_row_s1 : ram_rdata;
	assign tag_s1 = addr_s1 >> tsh;

	// Lookup, age update and victim choice
	always_comb begin
		logic [MAX_WAYS-1:0] w_v, w_d, act, vld, match, empty, cand;
		logic [TAG_W-1:0] w_tag [MAX_WAYS];
		logic [AGE_WIDTH-1:0] w_age [MAX_WAYS];
		logic [AGE_WIDTH-1:0] nage [MAX_WAYS];
		logic [WAY_W-1:0] slot;
		logic ok;
		logic has_empty;
		logic [WAY_AW-1:0] vic_e, vic_l, vic;
		logic [TAG_W-1:0] vtag;
		logic vdirty, vvalid;

		has_empty = 1'b0;
		vic_e = '0;
		vic_l = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			slot = row_s1[w*WAY_W +: WAY_W];
			w_v[w] = slot[WAY_W-1];
			w_d[w] = slot[WAY_W-2];
			w_tag[w] = slot[AGE_WIDTH +: TAG_W];
			w_age[w] = slot[AGE_WIDTH-1:0];
			act[w] = (w < int'(ways_n));
			vld[w] = act[w] && w_v[w];
			empty[w] = act[w] && !w_v[w];
			match[w] = vld[w] && (w_tag[w] == tag_s1);
			if (match[w]) begin
				nage[w] = '0;
			end else if (w_age[w] == {AGE_WIDTH{1'b1}}) begin
				nage[w] = w_age[w];
			end else begin
				nage[w] = w_age[w] + 1'b1;
			end
			if (empty[w]) begin
				has_empty = 1'b1;
				vic_e = WAY_AW'(w);
			end
		end

		// First valid way holding the greatest age
		for (int w = 0; w < MAX_WAYS; w++) begin
			ok = 1'b1;
			for (int u = 0; u < MAX_WAYS; u++) begin
				if (u != w && vld[u]) begin
					if (u < w) begin
						ok = ok && (nage[w] > nage[u]);
					end else begin
						ok = ok && (nage[w] >= nage[u]);
					end
				end
			end
			cand[w] = vld[w] && ok;
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (cand[w]) begin
				vic_l = WAY_AW'(w);
			end
		end

		hit = |match;
		vic = has_empty ? vic_e : vic_l;
		vtag = w_tag[vic];
		vdirty = w_d[vic];
		vvalid = w_v[vic] && act[vic];
		wb = !hit && vvalid && vdirty;
		wb_addr = wb ? ((vtag << tsh) | (addr_s1 & ~(ones << tsh) & (ones << log_block_q)))
			: '0;

		for (int w = 0; w < MAX_WAYS; w++) begin
			slot = row_s1[w*WAY_W +: WAY_W];
			if (!hit && vic == WAY_AW'(w)) begin
				slot = {1'b1, op_s1 == OP_WRITE, tag_s1, {AGE_WIDTH{1'b0}}};
			end else if (vld[w]) begin
				slot[AGE_WIDTH-1:0] = nage[w];
				slot[WAY_W-2] = w_d[w] || (match[w] && op_s1 == OP_WRITE);
			end
			new_row[w*WAY_W +: WAY_W] = slot;
		end
	end

	always_comb begin
		rd_acc_n = rd_acc_q + 32'(op_s1 == OP_READ);
		wr_acc_n = wr_acc_q + 32'(op_s1 == OP_WRITE);
		rd_miss_n = rd_miss_q + 32'(!hit && op_s1 == OP_READ);
		wr_miss_n = wr_miss_q + 32'(!hit && op_s1 == OP_WRITE);
		wb_tot_n = wb_tot_q + 32'(wb);
	end
endmodule

### design/slwc_checker.sv
// Port-level checks for the cache tag store, bound to the top level.
module slwc_checker (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input slwc_pkg::rsp_t rsp_data
);
	import slwc_pkg::*;

	// Stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result beat changed while stalled");

	a_fill_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.fill_valid != rsp_data.hit)
		else $error("fill request does not match miss");

	a_hit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.hit |-> !rsp_data.writeback_valid
			&& rsp_data.writeback_address == '0 && rsp_data.fill_address == '0)
		else $error("hit beat carries eviction or fill data");

	a_wb_needs_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.writeback_valid |-> rsp_data.fill_valid)
		else $error("writeback without miss");

	// Set sweep runs right after reset
	a_sweep_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready && !rsp_valid)
		else $error("request taken during set sweep");
endmodule

bind set_assoc_lru_writeback_cache slwc_checker u_slwc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);
